// ===== hdl/spit_pkg.sv =====
// Shared types and codes for the shape-in-polygon tester.
package spit_pkg;

    // Item operation codes
    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_TEST   = 2'd2;

    // Shape kinds for a test
    localparam logic [1:0] KIND_CIRCLE = 2'd0;
    localparam logic [1:0] KIND_RECT   = 2'd1;
    localparam logic [1:0] KIND_LINE   = 2'd2;
    localparam logic [1:0] KIND_TEXT   = 2'd3;

    // Fewest vertices that can enclose anything
    localparam int unsigned MIN_VERTICES = 3;

    // Number of test points walked in parallel
    localparam int unsigned NUM_LANES = 4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FEED,
        ST_DRAIN,
        ST_REPORT
    } t_state;

    // Vertex store write controls
    typedef struct packed {
        logic start;
        logic append;
    } t_load_ctl;

    // Edge lane controls
    typedef struct packed {
        logic clear;
        logic edge_v;
    } t_lane_ctl;

endpackage

// ===== hdl/spit_vstore.sv =====
// Vertex memory with fill count and overflow flag.
module spit_vstore #(
    parameter int MAX_VERTICES = 256,
    parameter int COORD_WIDTH  = 24,
    parameter int AW           = $clog2(MAX_VERTICES),
    parameter int CNTW         = $clog2(MAX_VERTICES + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  spit_pkg::t_load_ctl           i_load,
    input  logic signed [COORD_WIDTH-1:0] i_x,
    input  logic signed [COORD_WIDTH-1:0] i_y,
    input  logic                          i_rd_en,
    input  logic [AW-1:0]                 i_rd_addr,
    output logic signed [COORD_WIDTH-1:0] o_rd_x,
    output logic signed [COORD_WIDTH-1:0] o_rd_y,
    output logic [CNTW-1:0]               o_count,
    output logic                          o_overflow
);

    localparam int DW = 2 * COORD_WIDTH;

    logic [DW-1:0]   r_mem [MAX_VERTICES];
    logic [DW-1:0]   r_rd_data;
    logic [CNTW-1:0] r_count;
    logic            r_overflow;
    logic            full;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;

    // Append lands at the fill count; start always lands at entry zero
    assign full    = (r_count == CNTW'(MAX_VERTICES));
    assign wr_en   = i_load.start | (i_load.append & ~full);
    assign wr_addr = i_load.start ? '0 : r_count[AW-1:0];

    // Loads and test reads never overlap, so no forwarding is needed
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= {i_x, i_y};
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // Fill count and dropped-vertex flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_overflow <= 1'b0;
        end else if (i_load.start) begin
            r_count    <= CNTW'(1);
            r_overflow <= 1'b0;
        end else if (i_load.append) begin
            if (full) begin
                r_overflow <= 1'b1;
            end else begin
                r_count <= r_count + CNTW'(1);
            end
        end
    end

    assign o_rd_x     = r_rd_data[DW-1:COORD_WIDTH];
    assign o_rd_y     = r_rd_data[COORD_WIDTH-1:0];
    assign o_count    = r_count;
    assign o_overflow = r_overflow;

endmodule

// ===== hdl/spit_edge_lane.sv =====
// One test point's crossing-parity pipeline over the polygon edges.
module spit_edge_lane #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  spit_pkg::t_lane_ctl           i_ctl,
    input  logic signed [COORD_WIDTH:0]   i_px,
    input  logic signed [COORD_WIDTH:0]   i_py,
    input  logic signed [COORD_WIDTH-1:0] i_xi,
    input  logic signed [COORD_WIDTH-1:0] i_yi,
    input  logic signed [COORD_WIDTH-1:0] i_xj,
    input  logic signed [COORD_WIDTH-1:0] i_yj,
    output logic                          o_parity
);

    localparam int PW = COORD_WIDTH + 1;   // point and vertex difference width
    localparam int QW = COORD_WIDTH + 2;   // point minus vertex width
    localparam int MW = PW + QW;           // product width

    logic signed [PW-1:0] xi_e, yi_e, xj_e, yj_e;
    logic signed [QW-1:0] px_e, py_e, xi_q, yi_q;
    logic                 straddle;

    logic signed [QW-1:0] r_dxp, r_dyp;
    logic signed [PW-1:0] r_d, r_dxv;
    logic                 r_cross1;
    logic signed [MW-1:0] r_lhs, r_rhs;
    logic                 r_dneg;
    logic                 r_cross2;
    logic                 r_parity;
    logic                 flip;

    // Sign extension to working widths
    assign xi_e = PW'(i_xi);
    assign yi_e = PW'(i_yi);
    assign xj_e = PW'(i_xj);
    assign yj_e = PW'(i_yj);
    assign px_e = QW'(i_px);
    assign py_e = QW'(i_py);
    assign xi_q = QW'(i_xi);
    assign yi_q = QW'(i_yi);

    // Edge straddles the point's y when exactly one end lies above it
    assign straddle = (yi_e > i_py) != (yj_e > i_py);

    // Stage 1: differences
    always_ff @(posedge i_clk) begin
        r_dxp <= px_e - xi_q;
        r_dyp <= py_e - yi_q;
        r_d   <= yj_e - yi_e;
        r_dxv <= xj_e - xi_e;
    end

    // Stage 2: cross products, (px-xi)*(yj-yi) against (xj-xi)*(py-yi)
    always_ff @(posedge i_clk) begin
        r_lhs  <= MW'(r_dxp) * MW'(r_d);
        r_rhs  <= MW'(r_dxv) * MW'(r_dyp);
        r_dneg <= r_d[PW-1];
    end

    // Straddle flags ride along with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cross1 <= 1'b0;
            r_cross2 <= 1'b0;
        end else begin
            r_cross1 <= i_ctl.edge_v & straddle;
            r_cross2 <= r_cross1;
        end
    end

    // Point is left of the crossing; compare flips with the edge direction
    assign flip = r_cross2 & (r_dneg ? (r_lhs > r_rhs) : (r_lhs < r_rhs));

    // Stage 3: even-odd parity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parity <= 1'b0;
        end else if (i_ctl.clear) begin
            r_parity <= 1'b0;
        end else if (flip) begin
            r_parity <= ~r_parity;
        end
    end

    assign o_parity = r_parity;

endmodule

// ===== hdl/shape_in_polygon_test.sv =====
// Top level: command decode, edge walk sequencer and result strobe.
//
//  channel   handshake            ports
//  -------   ------------------   ------------------------------------------
//  command   start & !busy        i_operation, i_shape_kind, i_a_x/y, i_b_x/y
//  result    o_valid (1 cycle)    o_inside_res, o_vertex_overflow
//
// A load leaves the sequencer idle. A test against n stored vertices reads the
// vertex memory once per cycle (n + 1 reads, the last vertex first to close
// the polygon), then three pipeline stages drain; its result is shown in the
// report state, and the next command is taken once the sequencer is idle again.
// With fewer than three vertices the result follows in the next cycle.
// Reset clears the fill count, overflow flag and sequencer; memory contents
// are not cleared. The receiver cannot stall: each result is shown once.
module shape_in_polygon_test #(
    parameter int MAX_VERTICES = 256,
    parameter int COORD_WIDTH  = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_operation,
    input  logic [1:0]                    i_shape_kind,
    input  logic signed [COORD_WIDTH-1:0] i_a_x,
    input  logic signed [COORD_WIDTH-1:0] i_a_y,
    input  logic signed [COORD_WIDTH-1:0] i_b_x,
    input  logic signed [COORD_WIDTH-1:0] i_b_y,
    output logic                          o_valid,
    output logic                          o_inside_res,
    output logic                          o_vertex_overflow
);

    localparam int AW   = $clog2(MAX_VERTICES);
    localparam int CNTW = $clog2(MAX_VERTICES + 1);
    localparam int PW   = COORD_WIDTH + 1;
    localparam int NL   = spit_pkg::NUM_LANES;

    spit_pkg::t_state    r_state, n_state;
    spit_pkg::t_load_ctl load;
    spit_pkg::t_lane_ctl lane_ctl;

    logic                          accept;
    logic                          test_go;
    logic                          rd_en;
    logic [AW-1:0]                 r_addr;
    logic [AW-1:0]                 last_addr;
    logic                          r_head;
    logic                          r_rv, r_rv_head, r_v1, r_v2;
    logic signed [COORD_WIDTH-1:0] rd_x, rd_y;
    logic signed [COORD_WIDTH-1:0] r_prev_x, r_prev_y;
    logic [CNTW-1:0]               vcount;
    logic                          overflow;
    logic                          too_few;
    logic                          feed_done;
    logic                          pipe_empty;

    logic signed [PW-1:0] ax_e, ay_e, bx_e, by_e, sx, sy;
    logic signed [PW-1:0] pt_x [NL];
    logic signed [PW-1:0] pt_y [NL];
    logic signed [PW-1:0] r_px [NL];
    logic signed [PW-1:0] r_py [NL];
    logic [NL-1:0]        parity;

    // Command transfer and decode
    assign accept  = start & ~busy;
    assign test_go = accept & (i_operation == spit_pkg::OP_TEST);
    assign load.start  = accept & (i_operation == spit_pkg::OP_START);
    assign load.append = accept & (i_operation == spit_pkg::OP_APPEND);
    assign too_few = (vcount < CNTW'(spit_pkg::MIN_VERTICES));

    // Vertex memory
    spit_vstore #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_WIDTH  (COORD_WIDTH)
    ) u_vstore (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_x        (i_a_x),
        .i_y        (i_a_y),
        .i_rd_en    (rd_en),
        .i_rd_addr  (r_addr),
        .o_rd_x     (rd_x),
        .o_rd_y     (rd_y),
        .o_count    (vcount),
        .o_overflow (overflow)
    );

    // Test points, full precision sums
    assign ax_e = PW'(i_a_x);
    assign ay_e = PW'(i_a_y);
    assign bx_e = PW'(i_b_x);
    assign by_e = PW'(i_b_y);
    assign sx   = ax_e + bx_e;
    assign sy   = ay_e + by_e;

    // Unused lanes repeat a point already under test
    always_comb begin
        for (int k = 0; k < NL; k++) begin
            pt_x[k] = ax_e;
            pt_y[k] = ay_e;
        end
        unique case (i_shape_kind) inside
            spit_pkg::KIND_RECT: begin
                pt_x[1] = sx;
                pt_x[2] = sx;
                pt_y[2] = sy;
                pt_y[3] = sy;
            end
            spit_pkg::KIND_LINE: begin
                for (int k = 1; k < NL; k++) begin
                    pt_x[k] = bx_e;
                    pt_y[k] = by_e;
                end
            end
            spit_pkg::KIND_CIRCLE, spit_pkg::KIND_TEXT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (test_go) begin
            for (int k = 0; k < NL; k++) begin
                r_px[k] <= pt_x[k];
                r_py[k] <= pt_y[k];
            end
        end
    end

    // Edge walk: last vertex first, then 0 .. n-1
    assign last_addr = AW'(vcount - CNTW'(1));
    assign feed_done = ~r_head & (r_addr == last_addr);
    assign pipe_empty = ~r_rv & ~r_v1 & ~r_v2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
            r_head <= 1'b0;
        end else if (test_go) begin
            r_addr <= last_addr;
            r_head <= 1'b1;
        end else if (rd_en) begin
            r_addr <= r_head ? '0 : r_addr + AW'(1);
            r_head <= 1'b0;
        end
    end

    // Read-data valid and lane stage tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv      <= 1'b0;
            r_rv_head <= 1'b0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
        end else begin
            r_rv      <= rd_en;
            r_rv_head <= r_head;
            r_v1      <= lane_ctl.edge_v;
            r_v2      <= r_v1;
        end
    end

    // Previous vertex closes each edge
    always_ff @(posedge i_clk) begin
        if (r_rv) begin
            r_prev_x <= rd_x;
            r_prev_y <= rd_y;
        end
    end

    assign lane_ctl.clear  = test_go;
    assign lane_ctl.edge_v = r_rv & ~r_rv_head;

    // Point lanes
    for (genvar g = 0; g < NL; g++) begin : g_lane
        spit_edge_lane #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (lane_ctl),
            .i_px     (r_px[g]),
            .i_py     (r_py[g]),
            .i_xi     (rd_x),
            .i_yi     (rd_y),
            .i_xj     (r_prev_x),
            .i_yj     (r_prev_y),
            .o_parity (parity[g])
        );
    end

    // Sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spit_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            spit_pkg::ST_IDLE: begin
                if (test_go) begin
                    n_state = too_few ? spit_pkg::ST_REPORT : spit_pkg::ST_FEED;
                end
            end
            spit_pkg::ST_FEED: begin
                if (feed_done) begin
                    n_state = spit_pkg::ST_DRAIN;
                end
            end
            spit_pkg::ST_DRAIN: begin
                if (pipe_empty) begin
                    n_state = spit_pkg::ST_REPORT;
                end
            end
            spit_pkg::ST_REPORT: begin
                n_state = spit_pkg::ST_IDLE;
            end
            default: begin
                n_state = spit_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb begin
        busy    = 1'b1;
        rd_en   = 1'b0;
        o_valid = 1'b0;
        unique case (r_state)
            spit_pkg::ST_IDLE:   busy    = 1'b0;
            spit_pkg::ST_FEED:   rd_en   = 1'b1;
            spit_pkg::ST_DRAIN:  busy    = 1'b1;
            spit_pkg::ST_REPORT: o_valid = 1'b1;
            default:             busy    = 1'b1;
        endcase
    end

    // Parities are cleared at the test transfer, so a short polygon reads 0
    assign o_inside_res      = |parity;
    assign o_vertex_overflow = overflow;

endmodule
